// ===== design/vgtb_pkg.sv =====
package vgtb_pkg;

  // Field and register widths; the dimension widths follow from the largest dimension.
  localparam int unsigned MAX_DIM   = 4096;
  localparam int unsigned DIM_W     = $clog2(MAX_DIM) + 1;
  localparam int unsigned CNT_W     = $clog2(MAX_DIM);
  localparam int unsigned HALF_W    = $clog2(MAX_DIM);
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned FAC_W     = 17;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // Quotient bits produced by the factor divider, one per cycle.
  localparam int unsigned DIV_STEPS = 17;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_RED     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_GREEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_BLUE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_ALPHA   = 3'd5;

  // One RGBA pixel or color.
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } pixel_t;

  // A classified pixel waiting in the queue for the blend stage.
  typedef struct packed {
    pixel_t           px;
    logic [FAC_W-1:0] factor;
    logic             eoi;
  } qent_t;

  // Request to the row factor unit.
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] row;
    logic [DIM_W-1:0] height;
  } fac_req_t;

  // Status of the row factor unit.
  typedef struct packed {
    logic             busy;
    logic [FAC_W-1:0] factor;
  } fac_rsp_t;

  // A dimension of zero acts as one; anything above the maximum saturates.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // (1 - f) * pixel + f * tint with f in 16 fraction bits, truncated to a byte.
  function automatic logic [CHAN_W-1:0] blend(input logic [CHAN_W-1:0] p,
                                              input logic [CHAN_W-1:0] t,
                                              input logic [FAC_W-1:0]  f);
    logic [FAC_W-1:0]         inv;
    logic [FAC_W+CHAN_W:0]    acc;
    inv = FAC_W'((FAC_W+1)'(1) << FRAC_BITS) - f;
    acc = (FAC_W+CHAN_W+1)'(inv * p) + (FAC_W+CHAN_W+1)'(f * t);
    return acc[FRAC_BITS +: CHAN_W];
  endfunction

endpackage

// ===== design/vgtb_factor.sv =====
module vgtb_factor (
  input  logic               clk,
  input  logic               rst_n,
  input  vgtb_pkg::fac_req_t req,
  output vgtb_pkg::fac_rsp_t rsp
);

  typedef enum logic [3:0] {
    FAC_IDLE   = 4'b0001,
    FAC_SQUARE = 4'b0010,
    FAC_SCALE  = 4'b0100,
    FAC_DIVIDE = 4'b1000
  } fac_state_t;

  localparam int unsigned SQ_W  = 2 * vgtb_pkg::HALF_W - 1;
  localparam int unsigned DEN_W = SQ_W + 3;
  localparam int unsigned NUM_W = SQ_W + 2;
  localparam int unsigned STEP_W = $clog2(vgtb_pkg::DIV_STEPS);

  fac_state_t                      state_r, state_nxt;
  logic [vgtb_pkg::HALF_W-1:0]     dist_r, dist_nxt;
  logic [vgtb_pkg::HALF_W-1:0]     half_r, half_nxt;
  logic [SQ_W-1:0]                 dd_r, dd_nxt;
  logic [SQ_W-1:0]                 hh_r, hh_nxt;
  logic [DEN_W-1:0]                den_r, den_nxt;
  logic [DEN_W-1:0]                rem_r, rem_nxt;
  logic [vgtb_pkg::DIV_STEPS-1:0]  sh_r, sh_nxt;
  logic [vgtb_pkg::FAC_W-1:0]      quo_r, quo_nxt;
  logic [STEP_W-1:0]               step_r, step_nxt;
  logic [vgtb_pkg::FAC_W-1:0]      factor_r, factor_nxt;

  logic [vgtb_pkg::HALF_W-1:0]     half_in;
  logic [vgtb_pkg::HALF_W:0]       row_ext;
  logic [NUM_W-1:0]                num3;
  logic [DEN_W:0]                  trial;
  logic                            fits;

  assign rsp.busy   = (state_r != FAC_IDLE);
  assign rsp.factor = factor_r;

  // Sequencer: distance, squares, scaling, then one quotient bit per cycle.
  always_comb begin
    state_nxt  = state_r;
    dist_nxt   = dist_r;
    half_nxt   = half_r;
    dd_nxt     = dd_r;
    hh_nxt     = hh_r;
    den_nxt    = den_r;
    rem_nxt    = rem_r;
    sh_nxt     = sh_r;
    quo_nxt    = quo_r;
    step_nxt   = step_r;
    factor_nxt = factor_r;

    half_in = req.height[vgtb_pkg::DIM_W-1:1];
    row_ext = {1'b0, req.row};
    num3    = NUM_W'(dd_r) + NUM_W'({dd_r, 1'b0});
    trial   = {rem_r, sh_r[vgtb_pkg::DIV_STEPS-1]};
    fits    = (trial >= {1'b0, den_r});

    case (state_r)
      FAC_IDLE: begin
      end
      FAC_SQUARE: begin
        dd_nxt    = SQ_W'(dist_r * dist_r);
        hh_nxt    = SQ_W'(half_r * half_r);
        state_nxt = FAC_SCALE;
      end
      FAC_SCALE: begin
        // Dividend is 3*d*d shifted up by the fraction bits; the quotient fits 17 bits.
        den_nxt   = DEN_W'(hh_r) + DEN_W'({hh_r, 2'b00});
        rem_nxt   = DEN_W'(num3[NUM_W-1:1]);
        sh_nxt    = {num3[0], {(vgtb_pkg::DIV_STEPS-1){1'b0}}};
        quo_nxt   = '0;
        step_nxt  = '0;
        state_nxt = FAC_DIVIDE;
      end
      FAC_DIVIDE: begin
        rem_nxt  = fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
        quo_nxt  = {quo_r[vgtb_pkg::FAC_W-2:0], fits};
        sh_nxt   = {sh_r[vgtb_pkg::DIV_STEPS-2:0], 1'b0};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(vgtb_pkg::DIV_STEPS - 1)) begin
          factor_nxt = {quo_r[vgtb_pkg::FAC_W-2:0], fits};
          state_nxt  = FAC_IDLE;
        end
      end
      default: begin
        state_nxt = FAC_IDLE;
      end
    endcase

    // A new request always overrides a computation in flight.
    if (req.start) begin
      half_nxt = half_in;
      if ({1'b0, half_in} >= row_ext) begin
        dist_nxt = half_in - req.row;
      end else begin
        dist_nxt = req.row - half_in;
      end
      if (req.height < vgtb_pkg::DIM_W'(2)) begin
        // Too short for a gradient: the factor is zero.
        factor_nxt = '0;
        state_nxt  = FAC_IDLE;
      end else begin
        state_nxt = FAC_SQUARE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= FAC_IDLE;
      factor_r <= '0;
    end else begin
      state_r  <= state_nxt;
      factor_r <= factor_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    half_r <= half_nxt;
    dd_r   <= dd_nxt;
    hh_r   <= hh_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    sh_r   <= sh_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
  end

endmodule

// ===== design/vgtb_front.sv =====
module vgtb_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [vgtb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vgtb_pkg::DIM_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  vgtb_pkg::pixel_t                   in_px,
  input  vgtb_pkg::fac_rsp_t                 fac_rsp,
  output vgtb_pkg::fac_req_t                 fac_req,
  input  logic                               q_full,
  output logic                               q_push,
  output vgtb_pkg::qent_t                    q_data,
  output vgtb_pkg::pixel_t                   tint
);

  logic [vgtb_pkg::DIM_W-1:0] width_r, width_nxt;
  logic [vgtb_pkg::DIM_W-1:0] height_r, height_nxt;
  vgtb_pkg::pixel_t           tint_r, tint_nxt;
  logic [vgtb_pkg::CNT_W-1:0] col_r, col_nxt;
  logic [vgtb_pkg::CNT_W-1:0] row_r, row_nxt;

  logic accept;
  logic last_col;
  logic last_row;

  assign in_ready = !fac_rsp.busy && !q_full;
  assign accept   = in_valid && in_ready;
  assign last_col = (({1'b0, col_r} + vgtb_pkg::DIM_W'(1)) >= width_r);
  assign last_row = (({1'b0, row_r} + vgtb_pkg::DIM_W'(1)) >= height_r);
  assign tint     = tint_r;

  // Tag each beat with its row factor and the end of image mark.
  assign q_push        = accept;
  assign q_data.px     = in_px;
  assign q_data.factor = fac_rsp.factor;
  assign q_data.eoi    = last_col && last_row;

  // Raster counters, configuration writes and factor requests.
  always_comb begin
    width_nxt      = width_r;
    height_nxt     = height_r;
    tint_nxt       = tint_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    fac_req.start  = 1'b0;
    fac_req.row    = '0;
    fac_req.height = height_r;

    if (accept) begin
      if (!last_col) begin
        col_nxt = col_r + vgtb_pkg::CNT_W'(1);
      end else begin
        col_nxt       = '0;
        row_nxt       = last_row ? '0 : row_r + vgtb_pkg::CNT_W'(1);
        fac_req.start = 1'b1;
        fac_req.row   = row_nxt;
      end
    end

    if (cfg_we) begin
      case (cfg_index)
        vgtb_pkg::REG_IMAGE_WIDTH: begin
          width_nxt     = vgtb_pkg::clamp_dim(cfg_data);
          col_nxt       = '0;
          row_nxt       = '0;
          fac_req.start = 1'b1;
          fac_req.row   = '0;
        end
        vgtb_pkg::REG_IMAGE_HEIGHT: begin
          height_nxt     = vgtb_pkg::clamp_dim(cfg_data);
          col_nxt        = '0;
          row_nxt        = '0;
          fac_req.start  = 1'b1;
          fac_req.row    = '0;
          fac_req.height = height_nxt;
        end
        vgtb_pkg::REG_TINT_RED:   tint_nxt.red   = cfg_data[vgtb_pkg::CHAN_W-1:0];
        vgtb_pkg::REG_TINT_GREEN: tint_nxt.green = cfg_data[vgtb_pkg::CHAN_W-1:0];
        vgtb_pkg::REG_TINT_BLUE:  tint_nxt.blue  = cfg_data[vgtb_pkg::CHAN_W-1:0];
        vgtb_pkg::REG_TINT_ALPHA: tint_nxt.alpha = cfg_data[vgtb_pkg::CHAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= vgtb_pkg::DIM_W'(1);
      height_r <= vgtb_pkg::DIM_W'(1);
      tint_r   <= '0;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      tint_r   <= tint_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule

// ===== design/vgtb_queue.sv =====
module vgtb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  vgtb_pkg::qent_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output vgtb_pkg::qent_t head
);

  // Two-entry queue between the classifier and the blend stage.
  vgtb_pkg::qent_t mem_r [2];
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/vgtb_back.sv =====
module vgtb_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  vgtb_pkg::qent_t  q_head,
  output logic             q_pop,
  input  vgtb_pkg::pixel_t tint,
  output logic             out_valid,
  input  logic             out_ready,
  output vgtb_pkg::pixel_t out_px,
  output logic             out_eoi
);

  logic             valid_r;
  vgtb_pkg::pixel_t px_r, px_nxt;
  logic             eoi_r;

  // Take the queue head whenever the output register is free or drains.
  assign q_pop     = !q_empty && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_px    = px_r;
  assign out_eoi   = eoi_r;

  // Per-channel lerp toward the tint color.
  always_comb begin
    px_nxt.red   = vgtb_pkg::blend(q_head.px.red,   tint.red,   q_head.factor);
    px_nxt.green = vgtb_pkg::blend(q_head.px.green, tint.green, q_head.factor);
    px_nxt.blue  = vgtb_pkg::blend(q_head.px.blue,  tint.blue,  q_head.factor);
    px_nxt.alpha = vgtb_pkg::blend(q_head.px.alpha, tint.alpha, q_head.factor);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      px_r  <= px_nxt;
      eoi_r <= q_head.eoi;
    end
  end

endmodule

// ===== design/vertical_gradient_tint_blend.sv =====
// Vertical gradient tint blend.
// Pixels of an image enter in raster order on the in_ channel (valid/ready,
// one RGBA beat per pixel) and leave blended on the out_ channel, one beat
// per pixel, with out_end_of_image high on the last pixel of the image.
// Each row is blended toward the tint color by 0.6 * (|row - H/2| / (H/2))^2.
// Configuration is a plain write port: cfg_we, cfg_index, cfg_data. Writing
// the width or height restarts the image at row zero.
// An accepted input beat passes through the queue and then the output register.
// Within a row one pixel is taken per cycle while the queue is not full.
// After the last pixel of every row, and after a width or height write, the row
// factor divider runs (two setup steps, then 17 quotient bits) and in_ready is
// low while it runs. A height below two needs no division and keeps it idle.
// The divider is the one unit that sets this per-row cost.
// Reset (rst_n low, synchronous) sets width and height to 1, tint to zero,
// clears the counters and empties the pipeline.
// When the receiver stalls, a two-beat queue and the output register absorb
// the traffic and in_ready drops once they are full; nothing is lost.
module vertical_gradient_tint_blend (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [vgtb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vgtb_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [vgtb_pkg::CHAN_W-1:0]    in_red,
  input  logic [vgtb_pkg::CHAN_W-1:0]    in_green,
  input  logic [vgtb_pkg::CHAN_W-1:0]    in_blue,
  input  logic [vgtb_pkg::CHAN_W-1:0]    in_alpha,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [vgtb_pkg::CHAN_W-1:0]    out_red,
  output logic [vgtb_pkg::CHAN_W-1:0]    out_green,
  output logic [vgtb_pkg::CHAN_W-1:0]    out_blue,
  output logic [vgtb_pkg::CHAN_W-1:0]    out_alpha,
  output logic                           out_end_of_image
);

  vgtb_pkg::pixel_t   in_px;
  vgtb_pkg::pixel_t   out_px;
  vgtb_pkg::pixel_t   tint;
  vgtb_pkg::fac_req_t fac_req;
  vgtb_pkg::fac_rsp_t fac_rsp;
  vgtb_pkg::qent_t    q_data;
  vgtb_pkg::qent_t    q_head;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;

  assign in_px.red   = in_red;
  assign in_px.green = in_green;
  assign in_px.blue  = in_blue;
  assign in_px.alpha = in_alpha;

  assign out_red   = out_px.red;
  assign out_green = out_px.green;
  assign out_blue  = out_px.blue;
  assign out_alpha = out_px.alpha;

  // Classifier: counters, configuration and factor requests.
  vgtb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_px     (in_px),
    .fac_rsp   (fac_rsp),
    .fac_req   (fac_req),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data),
    .tint      (tint)
  );

  // Row factor divider.
  vgtb_factor u_factor (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fac_req),
    .rsp   (fac_rsp)
  );

  // Queue between classifier and blend stage.
  vgtb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Blend stage with output register.
  vgtb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .tint      (tint),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_px    (out_px),
    .out_eoi   (out_end_of_image)
  );

endmodule

// ===== dv/vertical_gradient_tint_blend_tb.sv =====
module vertical_gradient_tint_blend_tb;
  import vgtb_pkg::*;

  // Register indexes that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int QUIET_LIMIT  = 3000;
  localparam int SETTLE_CYCLES = 25;
  localparam int REPORT_LIMIT = 10;

  // One blended output beat as the block should produce it.
  typedef struct packed {
    pixel_t px;
    logic   eoi;
  } blended_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CHAN_W-1:0]    in_red = '0;
  logic [CHAN_W-1:0]    in_green = '0;
  logic [CHAN_W-1:0]    in_blue = '0;
  logic [CHAN_W-1:0]    in_alpha = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CHAN_W-1:0]    out_red;
  logic [CHAN_W-1:0]    out_green;
  logic [CHAN_W-1:0]    out_blue;
  logic [CHAN_W-1:0]    out_alpha;
  logic                 out_end_of_image;

  // Shadow of the block: image size, tint and raster position.
  logic [DIM_W-1:0]     shadow_width;
  logic [DIM_W-1:0]     shadow_height;
  pixel_t               shadow_tint;
  int unsigned          shadow_col;
  int unsigned          shadow_row;
  logic [FAC_W-1:0]     shadow_weight;

  blended_beat_t        pending_pixels[$];
  int                   fail_count = 0;
  int                   quiet_cycles = 0;
  int                   sender_idle_pct = 0;
  int                   recv_stall_pct = 0;

  vertical_gradient_tint_blend uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .in_alpha         (in_alpha),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_end_of_image (out_end_of_image)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The receiver decides each cycle whether to stall.
  always @(negedge clk) begin
    out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // A zero dimension acts as one and large values saturate at the maximum.
  function automatic logic [DIM_W-1:0] fold_dimension(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Tint weight of a row: 0.6 * (|row - half| / half)^2 with 16 fraction bits.
  function automatic logic [FAC_W-1:0] row_tint_weight(input int unsigned row,
                                                       input int unsigned height);
    longint unsigned half, gap, q;
    if (height < 2) begin
      return '0;
    end
    half = height / 2;
    gap = (row > half) ? (row - half) : (half - row);
    q = (64'd3 * gap * gap * 64'd65536) / (64'd5 * half * half);
    if (q > 64'd65536) begin
      q = 64'd65536;
    end
    return FAC_W'(q);
  endfunction

  // Weighted mix of one channel toward the tint, truncated to a byte.
  function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] p,
                                                    input logic [CHAN_W-1:0] t,
                                                    input logic [FAC_W-1:0]  w);
    longint unsigned wl, acc;
    wl = w;
    acc = (64'd65536 - wl) * p + wl * t;
    return acc[FRAC_BITS +: CHAN_W];
  endfunction

  function automatic void restart_shadow();
    shadow_col = 0;
    shadow_row = 0;
    shadow_weight = row_tint_weight(0, shadow_height);
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [DIM_W-1:0] d);
    case (idx)
      REG_IMAGE_WIDTH: begin
        shadow_width = fold_dimension(d);
        restart_shadow();
      end
      REG_IMAGE_HEIGHT: begin
        shadow_height = fold_dimension(d);
        restart_shadow();
      end
      REG_TINT_RED:   shadow_tint.red = d[CHAN_W-1:0];
      REG_TINT_GREEN: shadow_tint.green = d[CHAN_W-1:0];
      REG_TINT_BLUE:  shadow_tint.blue = d[CHAN_W-1:0];
      REG_TINT_ALPHA: shadow_tint.alpha = d[CHAN_W-1:0];
      default: ;
    endcase
  endfunction

  // Blend one pixel with the current row weight and advance the raster position.
  function automatic blended_beat_t blend_and_advance(input pixel_t px);
    blended_beat_t r;
    logic end_col, end_row;
    end_col = (shadow_col + 1 >= shadow_width);
    end_row = (shadow_row + 1 >= shadow_height);
    r.px.red = mix_channel(px.red, shadow_tint.red, shadow_weight);
    r.px.green = mix_channel(px.green, shadow_tint.green, shadow_weight);
    r.px.blue = mix_channel(px.blue, shadow_tint.blue, shadow_weight);
    r.px.alpha = mix_channel(px.alpha, shadow_tint.alpha, shadow_weight);
    r.eoi = end_col && end_row;
    if (!end_col) begin
      shadow_col++;
    end else begin
      shadow_col = 0;
      shadow_row = end_row ? 0 : shadow_row + 1;
      shadow_weight = row_tint_weight(shadow_row, shadow_height);
    end
    return r;
  endfunction

  // Tracks both channels and the config port at each rising edge: checks results, predicts new beats.
  always @(posedge clk) begin
    blended_beat_t got, want;
    pixel_t src;
    if (!rst_n) begin
      shadow_width = DIM_W'(1);
      shadow_height = DIM_W'(1);
      shadow_tint = '0;
      restart_shadow();
      pending_pixels.delete();
      quiet_cycles = 0;
    end else begin
      // Output beat against the oldest expectation.
      if (out_valid && out_ready) begin
        got.px.red = out_red;
        got.px.green = out_green;
        got.px.blue = out_blue;
        got.px.alpha = out_alpha;
        got.eoi = out_end_of_image;
        if (pending_pixels.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("unexpected output beat rgba %h eoi %b", got.px, got.eoi);
          end
        end else begin
          want = pending_pixels.pop_front();
          if (got.px.red !== want.px.red || got.px.green !== want.px.green ||
              got.px.blue !== want.px.blue || got.px.alpha !== want.px.alpha ||
              got.eoi !== want.eoi) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("output mismatch: expected rgba %h eoi %b, got rgba %h eoi %b",
                       want.px, want.eoi, got.px, got.eoi);
            end
          end
        end
      end
      if (cfg_we) begin
        apply_register(cfg_index, cfg_data);
      end
      if (in_valid && in_ready) begin
        src.red = in_red;
        src.green = in_green;
        src.blue = in_blue;
        src.alpha = in_alpha;
        pending_pixels.push_back(blend_and_advance(src));
      end
      // Watchdog on cycles where neither channel moves a beat.
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("vertical_gradient_tint_blend_tb NOT OK");
          $finish;
        end
      end
    end
  end

  // All driving tasks start and end just after a falling edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] d);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_image(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  task automatic set_tint(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] g,
                          input logic [DIM_W-1:0] b, input logic [DIM_W-1:0] a);
    write_reg(REG_TINT_RED, r);
    write_reg(REG_TINT_GREEN, g);
    write_reg(REG_TINT_BLUE, b);
    write_reg(REG_TINT_ALPHA, a);
  endtask

  // Offers one pixel beat, holding it until the block takes it.
  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_red = px.red;
    in_green = px.green;
    in_blue = px.blue;
    in_alpha = px.alpha;
    do begin
      @(posedge clk);
    end while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) begin
      send_pixel(pixel_t'($urandom));
    end
  endtask

  // Stops sending, waits for every expected beat, then lets the divider finish.
  task automatic settle();
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_idle(input int sender_pct, input int recv_pct);
    sender_idle_pct = sender_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Register values after reset: one-pixel image, zero tint, so pixels pass through.
  task automatic test_reset_pass_through();
    send_pixel(32'h0000_0000);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h5aa5_c33c);
    settle();
  endtask

  // Strongest and weakest rows against the brightest and darkest tint.
  task automatic test_blend_extremes();
    set_tint(13'd255, 13'd255, 13'd255, 13'h1fff);
    set_image(13'd2, 13'd2);
    send_pixel(32'h0000_0000);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h0000_0000);
    send_pixel(32'hffff_ffff);
    settle();
    set_tint(13'd0, 13'd0, 13'h1f00, 13'd0);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h0000_0000);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h8040_2010);
    settle();
    // Odd height: the last row is as far from the middle as the first.
    set_image(13'd1, 13'd3);
    send_random(3);
    settle();
    // Undecoded indexes must leave every register alone.
    write_reg(REG_SPARE_LO, 13'h1fff);
    write_reg(REG_SPARE_HI, 13'h1fff);
    send_random(1);
    settle();
  endtask

  // Zero and oversized dimensions.
  task automatic test_dimension_clamp();
    set_tint(13'd200, 13'd17, 13'd255, 13'd96);
    set_image(13'd0, 13'd0);
    send_random(2);
    settle();
    set_image(13'h1fff, 13'h1fff);
    send_random(3);
    settle();
    set_image(13'd4097, 13'd2);
    send_random(2);
    settle();
  endtask

  // The largest size along each axis: the top rows of a tall image, the start of a wide one.
  task automatic test_max_dimension_wrap();
    set_idle(0, 0);
    set_tint(13'd255, 13'd0, 13'd128, 13'd1);
    set_image(13'd1, 13'd5000);
    send_random(150);
    settle();
    set_image(13'd4096, 13'd1);
    send_random(100);
    settle();
  endtask

  // Mostly small sizes, with the odd large, oversized or zero value mixed in.
  function automatic logic [DIM_W-1:0] pick_dimension();
    logic [DIM_W-1:0] d;
    case ($urandom_range(0, 19))
      0:       d = '0;
      1:       d = DIM_W'($urandom_range(MAX_DIM + 1, 8191));
      2:       d = DIM_W'($urandom_range(100, MAX_DIM));
      default: d = DIM_W'($urandom_range(1, 12));
    endcase
    return d;
  endfunction

  // Random images under each idling pattern: some whole images, sent once or twice, others cut short.
  task automatic test_random_images();
    int sender_pcts[4] = '{0, 79, 0, 19};
    int recv_pcts[4] = '{0, 0, 79, 19};
    int budget, n, half_n;
    logic [DIM_W-1:0] w, h;
    for (int ph = 0; ph < 4; ph++) begin
      set_idle(sender_pcts[ph], recv_pcts[ph]);
      budget = 275;
      while (budget > 0) begin
        settle();
        if ($urandom_range(0, 9) == 0) begin
          // Tint change only: the image carries on from where it stopped.
          n = $urandom_range(1, 40);
        end else begin
          w = pick_dimension();
          h = pick_dimension();
          set_image(w, h);
          if (w >= 1 && w <= 12 && h >= 1 && h <= 12 && $urandom_range(0, 3) != 0) begin
            n = int'(w) * int'(h) * $urandom_range(1, 2);
          end else begin
            n = $urandom_range(1, 80);
          end
        end
        set_tint(DIM_W'($urandom), DIM_W'($urandom), DIM_W'($urandom), DIM_W'($urandom));
        if ($urandom_range(0, 3) == 0) begin
          write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, DIM_W'($urandom));
        end
        if ($urandom_range(0, 5) == 0) begin
          // Sender holds off mid-image until the output side is empty.
          half_n = n / 2;
          send_random(half_n);
          in_valid = 1'b0;
          while (pending_pixels.size() != 0) begin
            @(negedge clk);
          end
          send_random(n - half_n);
        end else begin
          send_random(n);
        end
        budget -= n;
      end
    end
    set_idle(0, 0);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_reset_pass_through();
    test_blend_extremes();
    test_dimension_clamp();
    test_max_dimension_wrap();
    test_random_images();
    settle();
    if (pending_pixels.size() != 0) begin
      fail_count++;
      $display("%0d expected output beats never arrived", pending_pixels.size());
    end
    if (fail_count == 0) begin
      $display("vertical_gradient_tint_blend_tb OK");
    end else begin
      $display("vertical_gradient_tint_blend_tb NOT OK");
    end
    $finish;
  end

endmodule
